// ----- hdl/spgu_pkg.sv -----
// shared types, constants and helpers for the speech period gain update block
package spgu_pkg;

  localparam int unsigned NumW  = 62;   // serial numerator shift register width
  localparam int unsigned RemW  = 35;   // partial remainder width
  localparam int unsigned DivW  = 32;   // divisor width
  localparam int unsigned GainW = 22;

  localparam logic [GainW-1:0] GainMax   = 22'h3FFFFF;
  localparam logic [GainW-1:0] Unity     = 22'd65536;
  localparam logic [GainW-1:0] GainReset = 22'd131072;

  // configuration register indexes
  localparam logic [2:0] RegTargetPeak  = 3'd0;
  localparam logic [2:0] RegMaxExp      = 3'd1;
  localparam logic [2:0] RegMaxComp     = 3'd2;
  localparam logic [2:0] RegThreshold   = 3'd3;
  localparam logic [2:0] RegRaiseStep   = 3'd4;
  localparam logic [2:0] RegFallStep    = 3'd5;
  localparam logic [2:0] RegInvert      = 3'd6;
  localparam logic [2:0] RegTargetRms   = 3'd7;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIVR = 8'b0000_0010,  // target peak / peak
    S_DIVX = 8'b0000_0100,  // mean square
    S_SQRT = 8'b0000_1000,  // rms
    S_DIVL = 8'b0001_0000,  // target rms / rms
    S_DIVD = 8'b0010_0000,  // step scaling
    S_DIVF = 8'b0100_0000,  // gain floor
    S_FIN  = 8'b1000_0000
  } state_e;

  // saturate a quotient to the gain range
  function automatic logic [GainW-1:0] sat_gain(input logic [NumW-1:0] v);
    sat_gain = (|v[NumW-1:GainW]) ? GainMax : v[GainW-1:0];
  endfunction

endpackage

// ----- hdl/speech_period_gain_update.sv -----
// speech period gain update: serial divide / square root sequencer and gain state
// sequence: raise periods run the ratio divide, step scaling and finish; fall periods
//   add the gain floor divide, and a nonzero target rms adds the mean square divide,
//   square root and rms limit divide; bypass items go straight to finish
// throughput: one item at a time, the next one is taken the cycle after the result
//   register loads, set by the shared bit-serial divide / root unit (one bit per cycle)
// reset: async active low; config and control registers reset, gain to 131072
module speech_period_gain_update import spgu_pkg::*; #(
  parameter int unsigned SAMPLE_HZ = 48000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        period_peak_i,
  input  logic [45:0]        period_square_sum_i,
  input  logic [15:0]        period_length_i,
  input  logic               bypass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [GainW-1:0]   gain_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned NW = $clog2(SAMPLE_HZ + 1);
  localparam int unsigned PW = 25 + NW;
  localparam logic [DivW-1:0] SrDiv = DivW'(SAMPLE_HZ * 256);

  // configuration registers
  logic [16:0] tpeak_q, thr_q, trms_q;
  logic [21:0] maxexp_q, maxcomp_q;
  logic [24:0] rstep_q, fstep_q;
  logic        inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpeak_q   <= 17'd62259;
      maxexp_q  <= 22'd131072;
      maxcomp_q <= 22'd131072;
      thr_q     <= 17'd0;
      rstep_q   <= 25'd16777;
      fstep_q   <= 25'd16777;
      inv_q     <= 1'b0;
      trms_q    <= 17'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        RegTargetPeak: tpeak_q   <= pwdata[16:0];
        RegMaxExp:     maxexp_q  <= pwdata[21:0];
        RegMaxComp:    maxcomp_q <= pwdata[21:0];
        RegThreshold:  thr_q     <= pwdata[16:0];
        RegRaiseStep:  rstep_q   <= pwdata[24:0];
        RegFallStep:   fstep_q   <= pwdata[24:0];
        RegInvert:     inv_q     <= pwdata[0];
        RegTargetRms:  trms_q    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[4:2])
      RegTargetPeak: prdata = {15'd0, tpeak_q};
      RegMaxExp:     prdata = {10'd0, maxexp_q};
      RegMaxComp:    prdata = {10'd0, maxcomp_q};
      RegThreshold:  prdata = {15'd0, thr_q};
      RegRaiseStep:  prdata = {7'd0, rstep_q};
      RegFallStep:   prdata = {7'd0, fstep_q};
      RegInvert:     prdata = {31'd0, inv_q};
      RegTargetRms:  prdata = {15'd0, trms_q};
      default:       prdata = 32'd0;
    endcase
  end
  assign pready = 1'b1;

  state_e state_q, state_d;
  logic [NumW-1:0] num_q, num_d, quo_q, quo_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [DivW-1:0] div_q, div_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [15:0]     len_q;
  logic [45:0]     sum_q;
  logic            byp_q, raise_q, above_q;
  logic [GainW-1:0] limit_q, floor_q, gain_q, res;
  logic [22:0]     delta_q;
  logic            out_valid_q, fire, accept, fin, ld;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign gain_o      = gain_q;
  assign fire        = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign fin         = (cnt_q == 6'd1);

  // one serial step: a quotient bit or a root bit
  logic [RemW:0] pr, trial, sub;
  logic          ge, sq;
  logic [NumW-1:0] stp_num, stp_quo;
  logic [RemW-1:0] stp_rem;
  always_comb begin
    sq = (state_q == S_SQRT);
    if (sq) begin
      pr    = {rem_q[RemW-2:0], num_q[NumW-1 -: 2]};
      trial = {3'd0, quo_q[30:0], 2'b01};
    end else begin
      pr    = {rem_q, num_q[NumW-1]};
      trial = {4'd0, div_q};
    end
    sub     = pr - trial;
    ge      = (pr >= trial);
    stp_rem = ge ? sub[RemW-1:0] : pr[RemW-1:0];
    stp_quo = {quo_q[NumW-2:0], ge};
    stp_num = sq ? {num_q[NumW-3:0], 2'b00} : {num_q[NumW-2:0], 1'b0};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = bypass_i ? S_FIN : S_DIVR;
      S_DIVR: if (fin) state_d = (trms_q != 17'd0) ? S_DIVX : S_DIVD;
      S_DIVX: if (fin) state_d = S_SQRT;
      S_SQRT: if (fin) state_d = S_DIVL;
      S_DIVL: if (fin) state_d = S_DIVD;
      S_DIVD: if (fin) state_d = raise_q ? S_FIN : S_DIVF;
      S_DIVF: if (fin) state_d = S_FIN;
      S_FIN:  if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // operand loading for the next serial run
  logic [15:0]   len_fix;
  logic [NW-1:0] nsamp;
  logic [PW-1:0] prod;
  always_comb begin
    len_fix = (len_q == 16'd0) ? 16'd1 : len_q;
    nsamp   = (32'(len_fix) < 32'(SAMPLE_HZ)) ? NW'(len_fix) : NW'(SAMPLE_HZ);
    prod    = PW'(raise_q ? rstep_q : fstep_q) * PW'(nsamp);
    ld      = (state_d != state_q);
    num_d = stp_num;
    quo_d = stp_quo;
    rem_d = stp_rem;
    div_d = div_q;
    cnt_d = cnt_q - 6'd1;
    if (ld) begin
      quo_d = '0;
      rem_d = '0;
      case (state_d)
        S_DIVR: begin
          num_d = {tpeak_q, 15'd0, 30'd0};
          div_d = {16'd0, period_peak_i};
          cnt_d = 6'd32;
        end
        S_DIVX: begin
          num_d = {sum_q, 16'd0};
          div_d = {16'd0, len_fix};
          cnt_d = 6'd62;
        end
        S_SQRT: begin
          num_d = stp_quo;
          cnt_d = 6'd31;
        end
        S_DIVL: begin
          num_d = {trms_q, 23'd0, 22'd0};
          div_d = {1'b0, stp_quo[30:0]};
          cnt_d = 6'd40;
        end
        S_DIVD: begin
          num_d = {prod, (NumW-PW)'(0)};
          div_d = SrDiv;
          cnt_d = 6'(PW);
        end
        S_DIVF: begin
          num_d = {1'b1, 61'd0};
          div_d = {10'd0, maxcomp_q};
          cnt_d = 6'd33;
        end
        default: begin
          num_d = num_q;
          cnt_d = 6'd0;
        end
      endcase
    end
  end

  // final gain from the collected limits and steps
  logic [GainW:0]   up;
  logic [GainW-1:0] st, down;
  always_comb begin
    st = (above_q && gain_q < Unity && rstep_q == 25'd0) ? Unity : gain_q;
    up = {1'b0, st} + {1'b0, delta_q[GainW-1:0]};
    down = ({1'b0, gain_q} > delta_q) ? GainW'({1'b0, gain_q} - delta_q) : '0;
    if (down < floor_q) down = floor_q;
    if (byp_q) res = Unity;
    else if (raise_q) res = (up < {1'b0, limit_q}) ? up[GainW-1:0] : limit_q;
    else res = (down < limit_q) ? down : limit_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= GainReset;
    end else begin
      state_q <= state_d;
      if (state_q != S_IDLE && state_q != S_FIN) cnt_q <= cnt_d;
      else if (ld) cnt_q <= cnt_d;
      if (fire) begin
        gain_q      <= res;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    if (accept) begin
      sum_q   <= period_square_sum_i;
      len_q   <= period_length_i;
      byp_q   <= bypass_i;
      raise_q <= inv_q ? ({period_peak_i, 1'b0} <= thr_q)
                       : ({period_peak_i, 1'b0} >= thr_q);
      above_q <= (period_peak_i == 16'd0) || (tpeak_q > {period_peak_i, 1'b0});
      floor_q <= '0;
    end
    if (fin && state_q == S_DIVR)
      limit_q <= (maxexp_q < sat_gain(stp_quo)) ? maxexp_q : sat_gain(stp_quo);
    if (fin && state_q == S_DIVL && sat_gain(stp_quo) < limit_q)
      limit_q <= sat_gain(stp_quo);
    if (fin && state_q == S_DIVD) delta_q <= stp_quo[22:0];
    if (fin && state_q == S_DIVF) floor_q <= sat_gain(stp_quo);
  end

  // checks
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN) else $error("result without finish");
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_FIN) |-> cnt_q != 6'd0)
    else $error("serial counter ran out in a run state");
  a_bypass_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && byp_q) |=> gain_q == Unity) else $error("bypass item not unity");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("second item taken while busy");

endmodule
